[rtl/slir_pkg.sv]
// ----------------------------------------------------------------------------
// slir_pkg: shared definitions for the sorted insertion list
// Capacity, widths, request and status codes, and the cell control struct.
// ----------------------------------------------------------------------------
package slir_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic ins;  // shift right from the insert point and drop the value in
		logic rem;  // shift left over the matching entry
	} slir_ctrl_t;

endpackage

[rtl/slir_cell.sv]
// ----------------------------------------------------------------------------
// slir_cell: one slot of the sorted array
// Holds one entry, compares it with the request value and takes its new
// content from itself, the request or a neighbor.
// ----------------------------------------------------------------------------
module slir_cell (
	input  logic                clk,
	input  slir_pkg::slir_ctrl_t ctrl,
	input  slir_pkg::value_t    value,
	input  logic                valid,
	input  logic                left_lt,
	input  slir_pkg::value_t    left_entry,
	input  slir_pkg::value_t    right_entry,
	output logic                lt,
	output logic                hit,
	output slir_pkg::value_t    entry
);
	import slir_pkg::*;

	value_t entry_q;

	assign entry = entry_q;
	// empty slots act as larger than anything
	assign lt    = valid && (entry_q < value);
	// first slot not below the value, and equal to it
	assign hit   = valid && !lt && left_lt && (entry_q == value);

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			entry_q <= left_lt ? value : left_entry;
		end else if (ctrl.rem && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

[rtl/sorted_list_insert_remove_top.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top: bounded sorted list of signed values
// Row of compare-and-shift cells with a registered result.
// ----------------------------------------------------------------------------
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// Every cell compares its entry with the request value in the same cycle and
// takes its neighbor's entry, and a new request can be taken every cycle
// while the result register is free or being drained. One result per request:
// status, count after the request and the smallest entry (zero and
// smallest_valid low when empty). Inserts into a full list and removes of
// an absent value leave the list unchanged.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  slir_pkg::value_t                value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [slir_pkg::STATUS_W-1:0]   status,
	output logic [slir_pkg::COUNT_W-1:0]    entry_count,
	output slir_pkg::value_t                smallest,
	output logic                            smallest_valid
);
	import slir_pkg::*;

	logic [OCC_W-1:0]    occ_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [31:0]         occ_ext;

	value_t               entry_w [CAPACITY];
	logic [CAPACITY-1:0]  lt_w;
	logic [CAPACITY-1:0]  hit_w;

	logic       accept;
	logic       full;
	logic       found;
	slir_ctrl_t ctrl;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (occ_q == OCC_W'(CAPACITY));
	assign found    = |hit_w;

	assign ctrl.ins = accept && (req_type == REQ_INSERT) && !full;
	assign ctrl.rem = accept && (req_type == REQ_REMOVE) && found;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_lt;
		value_t left_entry;
		value_t right_entry;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_entry = value;
		end else begin : g_mid
			assign left_lt    = lt_w[i-1];
			assign left_entry = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry_w[i];
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
		end

		slir_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.value       (value),
			.valid       (OCC_W'(i) < occ_q),
			.left_lt     (left_lt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.lt          (lt_w[i]),
			.hit         (hit_w[i]),
			.entry       (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.ins) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (ctrl.rem) begin
				occ_q <= occ_q - OCC_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type == REQ_INSERT) begin
				status_q <= full ? ST_FULL : ST_INSERTED;
			end else begin
				status_q <= found ? ST_REMOVED : ST_NOT_FOUND;
			end
		end
	end

	// the list only changes on an accepted request, taken only when no result is held or the held one is retired
	assign occ_ext        = 32'(occ_q);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_count    = occ_ext[COUNT_W-1:0];
	assign smallest_valid = (occ_q != '0);
	assign smallest       = smallest_valid ? entry_w[0] : '0;

endmodule
